/* sv/adsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 8;
    localparam int DRIVE_W    = 8;
    localparam int LIMIT_W    = 8;
    localparam int NPTS_W     = 4;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int PT_W       = 24;
    localparam int PT_IDX_W   = 3;

    // Behavior constants
    localparam int SAMPLES_PER_UPDATE = 10;
    localparam int GAIN_DIVISOR       = 16;
    localparam int TABLE_DEPTH        = 8;
    localparam int DRIVE_MAX          = 255;
    localparam int DEAD_BAND_RST      = 5;
    localparam int STEP_LIMIT_RST     = 10;

    // Serial divider geometry
    localparam int DIV_W     = 24;
    localparam int DEN_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NPTS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_C   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_D   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIMIT  = 3'd7;

    // Update sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_AVG_WAIT,
        S_END0,
        S_END1,
        S_SEARCH,
        S_MUL,
        S_INT,
        S_INT_WAIT,
        S_STEP,
        S_OUT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* sv/adsr_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one ADC tick per word
interface adsr_in_if;
    logic                             valid;
    logic                             ready;
    logic [adsr_pkg::SAMPLE_W-1:0]    sample;
    logic                             sample_ok;
    logic                             kill;

    modport source (output valid, output sample, output sample_ok, output kill,
                    input ready);
    modport sink   (input valid, input sample, input sample_ok, input kill,
                    output ready);
endinterface

// Output channel: one status word per tick
interface adsr_out_if;
    logic                             valid;
    logic                             ready;
    logic [adsr_pkg::DRIVE_W-1:0]     drive_level;
    logic                             updated;
    logic [adsr_pkg::SAMPLE_W-1:0]    average_value;
    logic [adsr_pkg::SAMPLE_W-1:0]    corrected_value;
    logic                             stopped;

    modport source (output valid, output drive_level, output updated,
                    output average_value, output corrected_value, output stopped,
                    input ready);
    modport sink   (input valid, input drive_level, input updated,
                    input average_value, input corrected_value, input stopped,
                    output ready);
endinterface

`default_nettype wire

/* sv/averaged_deadband_step_regulator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Averaged dead-band step regulator. Each input word is one ADC tick; each
// accepted word gives exactly one output word. A tick without an update
// (timeout, collecting, kill, or halted) posts its word at once. The tick that
// completes the sample set runs the update sequence: a bit-serial divide for
// the average, a search of the correction table that reads one point per
// cycle, and, for an interpolated value, a 12x12 multiply and a second pass
// through the same divider, then the step and the posting of the word. Both
// divides use the shared 24-step divider. The block takes no new word while
// an update runs. The user must write configuration with
// i_cfg_we/i_cfg_idx/i_cfg_data only while the block is idle; the block
// itself does not enforce this.
module averaged_deadband_step_regulator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    adsr_in_if.sink                             i_in,
    adsr_out_if.source                          o_out,
    input  wire                                 i_cfg_we,
    input  wire [adsr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [adsr_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SW = adsr_pkg::SAMPLE_W;

    // Configuration
    logic [SW-1:0]                      r_target;
    logic [adsr_pkg::NPTS_W-1:0]        r_npts;
    logic [adsr_pkg::CFG_W-1:0]         r_tab [4];
    logic [SW-1:0]                      r_dead;
    logic [adsr_pkg::LIMIT_W-1:0]       r_slim;

    // Regulator state
    adsr_pkg::t_state                   r_state, n_state;
    logic [adsr_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic [adsr_pkg::CNT_W-1:0]         r_count, n_count;
    logic [adsr_pkg::DRIVE_W-1:0]       r_drive, n_drive;
    logic [SW-1:0]                      r_avg, n_avg;
    logic [SW-1:0]                      r_cor, n_cor;
    logic                               r_halt, n_halt;

    // Search and interpolation scratch
    logic [adsr_pkg::PT_IDX_W-1:0]      r_idx, n_idx;
    logic [SW-1:0]                      r_x0, n_x0;
    logic [SW-1:0]                      r_y0, n_y0;
    logic [SW-1:0]                      r_dx, n_dx;
    logic [SW-1:0]                      r_dym, n_dym;
    logic [SW-1:0]                      r_den, n_den;
    logic                               r_neg, n_neg;
    logic [2*SW-1:0]                    r_prod, n_prod;

    // Output word
    logic                               r_ov, n_ov;
    logic [adsr_pkg::DRIVE_W-1:0]       r_o_drive, n_o_drive;
    logic                               r_o_upd, n_o_upd;
    logic [SW-1:0]                      r_o_avg, n_o_avg;
    logic [SW-1:0]                      r_o_cor, n_o_cor;
    logic                               r_o_stop, n_o_stop;

    logic                               w_accept;
    logic                               w_slot;
    logic [adsr_pkg::SUM_W-1:0]         w_sum_add;
    logic [adsr_pkg::CNT_W:0]           w_cnt_inc;
    logic                               w_trigger;
    logic [adsr_pkg::NPTS_W-1:0]        w_neff;
    logic [adsr_pkg::PT_IDX_W-1:0]      w_last;
    logic [adsr_pkg::PT_IDX_W-1:0]      w_pidx;
    logic [adsr_pkg::CFG_W-1:0]         w_word;
    logic [adsr_pkg::PT_W-1:0]          w_pt;
    logic [SW-1:0]                      w_praw;
    logic [SW-1:0]                      w_pcor;
    logic                               w_in_seg;
    logic [SW:0]                        w_dy;
    logic [SW:0]                        w_dy_mag;
    logic [SW-1:0]                      w_q;
    logic [SW:0]                        w_cor_int;
    logic [SW:0]                        w_err;
    logic [SW:0]                        w_mag;
    logic [SW:0]                        w_shift;
    logic [SW:0]                        w_lim;
    logic [SW+1:0]                      w_nd;
    logic [adsr_pkg::DRIVE_W-1:0]       w_drive_sat;

    adsr_pkg::t_div_req                 w_div_req;
    adsr_pkg::t_div_rsp                 w_div_rsp;

    // Shared divider
    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Handshake
    assign w_slot     = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == adsr_pkg::S_IDLE) && w_slot;
    assign w_accept   = i_in.valid && i_in.ready;

    // Sample accumulation
    assign w_sum_add = r_sum + adsr_pkg::SUM_W'(i_in.sample);
    assign w_cnt_inc = {1'b0, r_count} + 1'b1;
    assign w_trigger = i_in.sample_ok &&
                       (w_cnt_inc >= (adsr_pkg::CNT_W+1)'(adsr_pkg::SAMPLES_PER_UPDATE));

    // Table point read: one point per cycle
    assign w_neff = (r_npts > adsr_pkg::NPTS_W'(adsr_pkg::TABLE_DEPTH)) ?
                    adsr_pkg::NPTS_W'(adsr_pkg::TABLE_DEPTH) : r_npts;
    assign w_last = adsr_pkg::PT_IDX_W'(w_neff - 1'b1);

    always_comb begin
        case (r_state)
            adsr_pkg::S_END1:   w_pidx = w_last;
            adsr_pkg::S_SEARCH: w_pidx = r_idx;
            default:            w_pidx = '0;
        endcase
    end

    assign w_word = r_tab[w_pidx[adsr_pkg::PT_IDX_W-1:1]];
    assign w_pt   = w_pidx[0] ? w_word[adsr_pkg::CFG_W-1:adsr_pkg::PT_W]
                              : w_word[adsr_pkg::PT_W-1:0];
    assign w_praw = w_pt[SW-1:0];
    assign w_pcor = w_pt[2*SW-1:SW];

    // Segment test and slope sign
    assign w_in_seg = (r_avg >= r_x0) && (r_avg <= w_praw);
    assign w_dy     = {1'b0, w_pcor} - {1'b0, r_y0};
    assign w_dy_mag = w_dy[SW] ? ((SW+1)'(0) - w_dy) : w_dy;

    // Interpolated value from the divider quotient (truncated toward zero)
    assign w_q       = w_div_rsp.quotient[SW-1:0];
    assign w_cor_int = r_neg ? ({1'b0, r_y0} - {1'b0, w_q}) : ({1'b0, r_y0} + {1'b0, w_q});

    // Error, dead band, step limit and drive saturation
    assign w_err   = {1'b0, r_target} - {1'b0, r_cor};
    assign w_mag   = w_err[SW] ? ((SW+1)'(0) - w_err) : w_err;
    assign w_shift = (SW+1)'(w_mag / adsr_pkg::GAIN_DIVISOR);

    always_comb begin
        if (w_mag > {1'b0, r_dead}) begin
            w_lim = (w_shift > (SW+1)'(r_slim)) ? (SW+1)'(r_slim) : w_shift;
        end else begin
            w_lim = '0;
        end
    end

    assign w_nd = w_err[SW] ? ((SW+2)'(r_drive) - {1'b0, w_lim})
                            : ((SW+2)'(r_drive) + {1'b0, w_lim});

    always_comb begin
        if (w_nd[SW+1]) begin
            w_drive_sat = '0;
        end else if (w_nd > (SW+2)'(adsr_pkg::DRIVE_MAX)) begin
            w_drive_sat = adsr_pkg::DRIVE_W'(adsr_pkg::DRIVE_MAX);
        end else begin
            w_drive_sat = w_nd[adsr_pkg::DRIVE_W-1:0];
        end
    end

    // Divider requests
    assign w_div_req.start    = (r_state == adsr_pkg::S_AVG) || (r_state == adsr_pkg::S_INT);
    assign w_div_req.dividend = (r_state == adsr_pkg::S_AVG) ?
                                adsr_pkg::DIV_W'(r_sum) : r_prod;
    assign w_div_req.divisor  = (r_state == adsr_pkg::S_AVG) ?
                                adsr_pkg::DEN_W'(adsr_pkg::SAMPLES_PER_UPDATE) : r_den;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            adsr_pkg::S_IDLE: begin
                if (w_accept && !r_halt && !i_in.kill && w_trigger) begin
                    n_state = adsr_pkg::S_AVG;
                end
            end
            adsr_pkg::S_AVG:      n_state = adsr_pkg::S_AVG_WAIT;
            adsr_pkg::S_AVG_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = adsr_pkg::S_END0;
                end
            end
            adsr_pkg::S_END0: begin
                if (w_neff < 2 || r_avg <= w_praw) begin
                    n_state = adsr_pkg::S_STEP;
                end else begin
                    n_state = adsr_pkg::S_END1;
                end
            end
            adsr_pkg::S_END1: begin
                if (r_avg >= w_praw) begin
                    n_state = adsr_pkg::S_STEP;
                end else begin
                    n_state = adsr_pkg::S_SEARCH;
                end
            end
            adsr_pkg::S_SEARCH: begin
                if (w_in_seg) begin
                    n_state = (w_praw == r_x0) ? adsr_pkg::S_STEP : adsr_pkg::S_MUL;
                end else if (r_idx == w_last) begin
                    n_state = adsr_pkg::S_STEP;
                end
            end
            adsr_pkg::S_MUL:      n_state = adsr_pkg::S_INT;
            adsr_pkg::S_INT:      n_state = adsr_pkg::S_INT_WAIT;
            adsr_pkg::S_INT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = adsr_pkg::S_STEP;
                end
            end
            adsr_pkg::S_STEP:     n_state = adsr_pkg::S_OUT;
            adsr_pkg::S_OUT: begin
                if (w_slot) begin
                    n_state = adsr_pkg::S_IDLE;
                end
            end
            default:              n_state = adsr_pkg::S_IDLE;
        endcase
    end

    // Datapath and output word
    always_comb begin
        n_sum     = r_sum;
        n_count   = r_count;
        n_drive   = r_drive;
        n_avg     = r_avg;
        n_cor     = r_cor;
        n_halt    = r_halt;
        n_idx     = r_idx;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_dx      = r_dx;
        n_dym     = r_dym;
        n_den     = r_den;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_ov      = r_ov && !o_out.ready;
        n_o_drive = r_o_drive;
        n_o_upd   = r_o_upd;
        n_o_avg   = r_o_avg;
        n_o_cor   = r_o_cor;
        n_o_stop  = r_o_stop;

        case (r_state)
            adsr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!r_halt && i_in.kill) begin
                        n_drive = '0;
                        n_halt  = 1'b1;
                    end else if (!r_halt && i_in.sample_ok) begin
                        n_sum   = w_sum_add;
                        n_count = w_cnt_inc[adsr_pkg::CNT_W-1:0];
                    end
                    // Word posted at once unless an update starts
                    if (r_halt || i_in.kill || !w_trigger) begin
                        n_ov      = 1'b1;
                        n_o_drive = (r_halt || i_in.kill) ? '0 : r_drive;
                        n_o_upd   = 1'b0;
                        n_o_avg   = r_avg;
                        n_o_cor   = r_cor;
                        n_o_stop  = r_halt || i_in.kill;
                    end
                end
            end
            adsr_pkg::S_AVG: begin
                n_sum   = '0;
                n_count = '0;
            end
            adsr_pkg::S_AVG_WAIT: begin
                if (w_div_rsp.done) begin
                    n_avg = w_div_rsp.quotient[SW-1:0];
                end
            end
            adsr_pkg::S_END0: begin
                if (w_neff < 2) begin
                    n_cor = r_avg;
                end else if (r_avg <= w_praw) begin
                    n_cor = w_pcor;
                end else begin
                    n_x0 = w_praw;
                    n_y0 = w_pcor;
                end
            end
            adsr_pkg::S_END1: begin
                if (r_avg >= w_praw) begin
                    n_cor = w_pcor;
                end else begin
                    n_idx = adsr_pkg::PT_IDX_W'(1);
                end
            end
            adsr_pkg::S_SEARCH: begin
                if (w_in_seg) begin
                    if (w_praw == r_x0) begin
                        n_cor = r_y0;
                    end else begin
                        n_dx  = r_avg - r_x0;
                        n_den = w_praw - r_x0;
                        n_neg = w_dy[SW];
                        n_dym = w_dy_mag[SW-1:0];
                    end
                end else if (r_idx == w_last) begin
                    // no bracketing segment in an unsorted table
                    n_cor = r_avg;
                end else begin
                    n_x0  = w_praw;
                    n_y0  = w_pcor;
                    n_idx = r_idx + 1'b1;
                end
            end
            adsr_pkg::S_MUL: begin
                n_prod = r_dx * r_dym;
            end
            adsr_pkg::S_INT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_cor = w_cor_int[SW-1:0];
                end
            end
            adsr_pkg::S_STEP: begin
                n_drive = w_drive_sat;
            end
            adsr_pkg::S_OUT: begin
                if (w_slot) begin
                    n_ov      = 1'b1;
                    n_o_drive = r_drive;
                    n_o_upd   = 1'b1;
                    n_o_avg   = r_avg;
                    n_o_cor   = r_cor;
                    n_o_stop  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adsr_pkg::S_IDLE;
            r_sum   <= '0;
            r_count <= '0;
            r_drive <= '0;
            r_avg   <= '0;
            r_cor   <= '0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_drive <= n_drive;
            r_avg   <= n_avg;
            r_cor   <= n_cor;
            r_halt  <= n_halt;
            r_ov    <= n_ov;
        end
    end

    // Scratch and output payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_dx      <= n_dx;
        r_dym     <= n_dym;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
        r_o_drive <= n_o_drive;
        r_o_upd   <= n_o_upd;
        r_o_avg   <= n_o_avg;
        r_o_cor   <= n_o_cor;
        r_o_stop  <= n_o_stop;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_npts   <= '0;
            r_tab[0] <= '0;
            r_tab[1] <= '0;
            r_tab[2] <= '0;
            r_tab[3] <= '0;
            r_dead   <= SW'(adsr_pkg::DEAD_BAND_RST);
            r_slim   <= adsr_pkg::LIMIT_W'(adsr_pkg::STEP_LIMIT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsr_pkg::CFG_TARGET: r_target <= i_cfg_data[SW-1:0];
                adsr_pkg::CFG_NPTS:   r_npts   <= i_cfg_data[adsr_pkg::NPTS_W-1:0];
                adsr_pkg::CFG_TAB_A:  r_tab[0] <= i_cfg_data;
                adsr_pkg::CFG_TAB_B:  r_tab[1] <= i_cfg_data;
                adsr_pkg::CFG_TAB_C:  r_tab[2] <= i_cfg_data;
                adsr_pkg::CFG_TAB_D:  r_tab[3] <= i_cfg_data;
                adsr_pkg::CFG_DEAD:   r_dead   <= i_cfg_data[SW-1:0];
                adsr_pkg::CFG_SLIMIT: r_slim   <= i_cfg_data[adsr_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output word
    assign o_out.valid           = r_ov;
    assign o_out.drive_level     = r_o_drive;
    assign o_out.updated         = r_o_upd;
    assign o_out.average_value   = r_o_avg;
    assign o_out.corrected_value = r_o_cor;
    assign o_out.stopped         = r_o_stop;

endmodule

`default_nettype wire

/* sv/adsr_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
// Quotient is valid in the cycle that done is high.
module adsr_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  adsr_pkg::t_div_req  i_req,
    output adsr_pkg::t_div_rsp  o_rsp
);

    localparam logic [adsr_pkg::DIV_CNT_W-1:0] LAST_STEP =
        adsr_pkg::DIV_CNT_W'(adsr_pkg::DIV_W - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [adsr_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [adsr_pkg::DEN_W-1:0]          r_den;
    logic [adsr_pkg::DEN_W-1:0]          r_rem;
    logic [adsr_pkg::DIV_W-1:0]          r_quo;

    logic [adsr_pkg::DEN_W:0]            w_trial;
    logic [adsr_pkg::DEN_W:0]            w_diff;
    logic                                w_fit;

    // Shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_quo[adsr_pkg::DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[adsr_pkg::DEN_W-1:0] : w_trial[adsr_pkg::DEN_W-1:0];
            r_quo <= {r_quo[adsr_pkg::DIV_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
